// File: rtl/bdc_pkg.sv
package bdc_pkg;

  // Pipeline sizing
  localparam int MAX_COEFFS = 7;
  localparam int FRAC_BITS  = 16;
  localparam int NUM_PASSES = MAX_COEFFS - 1;
  localparam int PASS_W     = $clog2(MAX_COEFFS);

  // Field and register widths
  localparam int T_W        = 18;
  localparam int COEF_W     = 32;
  localparam int CNT_W      = 3;
  localparam int NUM_COEF_REGS = 7;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  // Blend arithmetic: a + ((t * (b - a) + HALF) >>> FRAC_BITS)
  localparam int DIFF_W     = COEF_W + 1;
  localparam int PROD_W     = DIFF_W + T_W;
  localparam int ONE        = 1 << FRAC_BITS;
  localparam int HALF       = 1 << (FRAC_BITS - 1);

  // Register indexes of the configuration port
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_COEFF_COUNT = 3'd0,
    REG_COEF_0      = 3'd1,
    REG_COEF_1      = 3'd2,
    REG_COEF_2      = 3'd3,
    REG_COEF_3      = 3'd4,
    REG_COEF_4      = 3'd5,
    REG_COEF_5      = 3'd6,
    REG_COEF_6      = 3'd7
  } cfg_reg_t;

  typedef struct packed {
    logic [CNT_W-1:0]                          coeff_count;
    logic [NUM_COEF_REGS-1:0][COEF_W-1:0]      coef;
  } cfg_t;

  // One item in flight through the reduction passes
  typedef struct packed {
    logic                                      err;
    logic [PASS_W-1:0]                         left;
    logic signed [T_W-1:0]                     t;
    logic [MAX_COEFFS-1:0][COEF_W-1:0]         w;
  } item_t;

endpackage

// File: rtl/bdc_if.sv
interface bdc_in_if;
  logic                            valid;
  logic                            ready;
  logic signed [bdc_pkg::T_W-1:0]  t_param;

  modport source (output valid, output t_param, input ready);
  modport sink   (input valid, input t_param, output ready);
endinterface

interface bdc_out_if;
  logic                               valid;
  logic                               ready;
  logic signed [bdc_pkg::COEF_W-1:0]  value;
  logic                               param_error;

  modport source (output valid, output value, output param_error, input ready);
  modport sink   (input valid, input value, input param_error, output ready);
endinterface

// File: rtl/bdc_cfg.sv
module bdc_cfg (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_we,
  input  logic [bdc_pkg::CFG_IDX_W-1:0]      cfg_idx,
  input  logic [bdc_pkg::CFG_DATA_W-1:0]     cfg_data,
  output bdc_pkg::cfg_t                      cfg
);

  bdc_pkg::cfg_t regs;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.coeff_count <= bdc_pkg::CNT_W'(1);
      regs.coef        <= '0;
    end else if (cfg_we) begin
      case (bdc_pkg::cfg_reg_t'(cfg_idx))
        bdc_pkg::REG_COEFF_COUNT: regs.coeff_count <= cfg_data[bdc_pkg::CNT_W-1:0];
        bdc_pkg::REG_COEF_0:      regs.coef[0] <= cfg_data[bdc_pkg::COEF_W-1:0];
        bdc_pkg::REG_COEF_1:      regs.coef[1] <= cfg_data[bdc_pkg::COEF_W-1:0];
        bdc_pkg::REG_COEF_2:      regs.coef[2] <= cfg_data[bdc_pkg::COEF_W-1:0];
        bdc_pkg::REG_COEF_3:      regs.coef[3] <= cfg_data[bdc_pkg::COEF_W-1:0];
        bdc_pkg::REG_COEF_4:      regs.coef[4] <= cfg_data[bdc_pkg::COEF_W-1:0];
        bdc_pkg::REG_COEF_5:      regs.coef[5] <= cfg_data[bdc_pkg::COEF_W-1:0];
        bdc_pkg::REG_COEF_6:      regs.coef[6] <= cfg_data[bdc_pkg::COEF_W-1:0];
        default: ;
      endcase
    end
  end

  assign cfg = regs;

endmodule

// File: rtl/bdc_stage.sv
module bdc_stage (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  bdc_pkg::item_t   in_item,
  output logic             out_valid,
  input  logic             out_ready,
  output bdc_pkg::item_t   out_item
);

  logic                  valid;
  bdc_pkg::item_t        item;
  bdc_pkg::item_t        item_next;
  logic [bdc_pkg::MAX_COEFFS-2:0][bdc_pkg::COEF_W-1:0] blended;

  // One lane per adjacent pair; all lanes work in parallel
  for (genvar i = 0; i < bdc_pkg::MAX_COEFFS - 1; i++) begin : g_lane
    logic signed [bdc_pkg::COEF_W-1:0] a;
    logic signed [bdc_pkg::COEF_W-1:0] b;
    logic signed [bdc_pkg::DIFF_W-1:0] diff;
    logic signed [bdc_pkg::PROD_W-1:0] prod;
    logic signed [bdc_pkg::PROD_W-1:0] sum;
    logic signed [bdc_pkg::PROD_W-1:0] step;

    assign a    = in_item.w[i];
    assign b    = in_item.w[i+1];
    assign diff = bdc_pkg::DIFF_W'(b) - bdc_pkg::DIFF_W'(a);
    assign prod = bdc_pkg::PROD_W'(diff) * bdc_pkg::PROD_W'(in_item.t);
    assign sum  = prod + bdc_pkg::PROD_W'(bdc_pkg::HALF);
    assign step = sum >>> bdc_pkg::FRAC_BITS;
    assign blended[i] = a + step[bdc_pkg::COEF_W-1:0];
  end

  // Apply a pass only while passes remain; later stages carry w[0] unchanged
  always_comb begin
    item_next = in_item;
    if (in_item.left != '0) begin
      item_next.left = in_item.left - bdc_pkg::PASS_W'(1);
      for (int i = 0; i < bdc_pkg::MAX_COEFFS - 1; i++) begin
        item_next.w[i] = blended[i];
      end
    end
  end

  assign in_ready = !valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      item <= item_next;
    end
  end

  assign out_valid = valid;
  assign out_item  = item;

endmodule

// File: rtl/bernstein_de_casteljau_eval.sv
// Channel  Role   Handshake     Payload
// -------  -----  ------------  ---------------------------------------
// req      sink   valid/ready   t_param  (signed Q.16, 18 bits)
// rsp      source valid/ready   value (signed Q16.16), param_error
// cfg      write  cfg_we        cfg_idx (register index), cfg_data
//
// One request enters per cycle while rsp does not stall; the result passes one entry
// register plus one register per reduction pass (MAX_COEFFS-1) before it appears.
// Reset (rst, synchronous) clears all stage valid bits and sets the count to 1
// with all coefficients zero. A stall on rsp freezes the stages that are full
// back to the entry; empty stages still fill, so nothing is lost or repeated.
module bernstein_de_casteljau_eval (
  input  logic                            clk,
  input  logic                            rst,
  bdc_in_if.sink                          req,
  bdc_out_if.source                       rsp,
  input  logic                            cfg_we,
  input  logic [bdc_pkg::CFG_IDX_W-1:0]   cfg_idx,
  input  logic [bdc_pkg::CFG_DATA_W-1:0]  cfg_data
);

  bdc_pkg::cfg_t cfg;

  bdc_cfg u_cfg (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_data (cfg_data),
    .cfg      (cfg)
  );

  // Chain position 0 is the entry register; position k is the output of pass k
  logic           chain_valid [bdc_pkg::NUM_PASSES+1];
  logic           chain_ready [bdc_pkg::NUM_PASSES+1];
  bdc_pkg::item_t chain_item  [bdc_pkg::NUM_PASSES+1];

  // Entry stage: range check, clamp the count, snapshot the coefficients.
  // Configuration must only change while idle (the block does not enforce it), so the snapshot matches the model.
  logic                    entry_valid;
  bdc_pkg::item_t          entry;
  bdc_pkg::item_t          entry_next;
  logic [bdc_pkg::CNT_W-1:0] count_clamped;
  logic                    req_ready;

  always_comb begin
    // Count of zero acts as one; a count above the limit is held at the limit
    count_clamped = cfg.coeff_count;
    if (cfg.coeff_count == '0) begin
      count_clamped = bdc_pkg::CNT_W'(1);
    end else if (cfg.coeff_count > bdc_pkg::CNT_W'(bdc_pkg::MAX_COEFFS)) begin
      count_clamped = bdc_pkg::CNT_W'(bdc_pkg::MAX_COEFFS);
    end
    entry_next.t    = req.t_param;
    entry_next.err  = req.t_param[bdc_pkg::T_W-1] ||
                      (int'(req.t_param) > bdc_pkg::ONE);
    entry_next.left = bdc_pkg::PASS_W'(count_clamped - bdc_pkg::CNT_W'(1));
    for (int i = 0; i < bdc_pkg::MAX_COEFFS; i++) begin
      entry_next.w[i] = cfg.coef[i];
    end
  end

  assign req_ready = !entry_valid || chain_ready[0];
  assign req.ready = req_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_valid <= 1'b0;
    end else if (req_ready) begin
      entry_valid <= req.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req_ready && req.valid) begin
      entry <= entry_next;
    end
  end

  assign chain_valid[0] = entry_valid;
  assign chain_item[0]  = entry;

  // One stage per reduction pass
  for (genvar p = 0; p < bdc_pkg::NUM_PASSES; p++) begin : g_pass
    bdc_stage u_stage (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (chain_valid[p]),
      .in_ready  (chain_ready[p]),
      .in_item   (chain_item[p]),
      .out_valid (chain_valid[p+1]),
      .out_ready (chain_ready[p+1]),
      .out_item  (chain_item[p+1])
    );
  end

  // Last pass register doubles as the output register
  assign chain_ready[bdc_pkg::NUM_PASSES] = rsp.ready;
  assign rsp.valid       = chain_valid[bdc_pkg::NUM_PASSES];
  assign rsp.param_error = chain_item[bdc_pkg::NUM_PASSES].err;
  assign rsp.value       = chain_item[bdc_pkg::NUM_PASSES].err ? '0 :
                           chain_item[bdc_pkg::NUM_PASSES].w[0];

endmodule

// File: tb/testbench.sv
module testbench;
  import bdc_pkg::*;

  // Pipeline depth: the entry register plus one register per pass.
  localparam int PIPE_LATENCY    = 7;
  localparam int DRAIN_CYCLES    = 4 * PIPE_LATENCY;
  localparam int HOLD_CYCLES     = 60;
  localparam int NUM_PHASES      = 8;
  localparam int ITEMS_PER_PHASE = 150;
  localparam int CYCLE_LIMIT     = 200_000;

  localparam logic [COEF_W-1:0] COEF_MAX = 32'h7FFF_FFFF;
  localparam logic [COEF_W-1:0] COEF_MIN = 32'h8000_0000;

  // One evaluation as it should leave the block; t kept for messages.
  typedef struct packed {
    logic signed [T_W-1:0]    t;
    logic signed [COEF_W-1:0] value;
    logic                     param_error;
  } eval_result_t;

  // Directed table: a register write, a request checked against the
  // predictor, or a request whose result is typed into the row.
  typedef enum logic [1:0] {
    ROW_WRITE,
    ROW_EVAL,
    ROW_EVAL_TYPED
  } row_kind_t;

  typedef struct packed {
    row_kind_t                kind;
    cfg_reg_t                 idx;
    logic [CFG_DATA_W-1:0]    data;       // register value, or t in the low bits
    logic signed [COEF_W-1:0] exp_value;
    logic                     exp_err;
  } row_t;

  localparam int NUM_ROWS = 36;
  localparam row_t DIRECTED_ROWS [NUM_ROWS] = '{
    // Out of reset: one coefficient, zero. Range edges and all error cases.
    '{ROW_EVAL_TYPED, REG_COEFF_COUNT, 32'h0000_0000, 32'h0000_0000, 1'b0},
    '{ROW_EVAL_TYPED, REG_COEFF_COUNT, 32'h0001_0000, 32'h0000_0000, 1'b0},
    '{ROW_EVAL_TYPED, REG_COEFF_COUNT, 32'hFFFF_FFFF, 32'h0000_0000, 1'b1},
    '{ROW_EVAL_TYPED, REG_COEFF_COUNT, 32'h0001_0001, 32'h0000_0000, 1'b1},
    '{ROW_EVAL_TYPED, REG_COEFF_COUNT, 32'h0002_0000, 32'h0000_0000, 1'b1},
    '{ROW_EVAL_TYPED, REG_COEFF_COUNT, 32'h0001_FFFF, 32'h0000_0000, 1'b1},
    // Count of zero behaves as one: result is coef_0 at any legal t.
    '{ROW_WRITE,      REG_COEFF_COUNT, 32'h0000_0000, 32'h0000_0000, 1'b0},
    '{ROW_WRITE,      REG_COEF_0,      32'h7FFF_FFFF, 32'h0000_0000, 1'b0},
    '{ROW_EVAL_TYPED, REG_COEFF_COUNT, 32'h0000_8000, 32'h7FFF_FFFF, 1'b0},
    // Linear blend between the two extremes of the coefficient range.
    '{ROW_WRITE,      REG_COEFF_COUNT, 32'h0000_0002, 32'h0000_0000, 1'b0},
    '{ROW_WRITE,      REG_COEF_0,      32'h8000_0000, 32'h0000_0000, 1'b0},
    '{ROW_WRITE,      REG_COEF_1,      32'h7FFF_FFFF, 32'h0000_0000, 1'b0},
    '{ROW_EVAL_TYPED, REG_COEFF_COUNT, 32'h0000_0000, 32'h8000_0000, 1'b0},
    '{ROW_EVAL_TYPED, REG_COEFF_COUNT, 32'h0001_0000, 32'h7FFF_FFFF, 1'b0},
    '{ROW_EVAL,       REG_COEFF_COUNT, 32'h0000_8000, 32'h0000_0000, 1'b0},
    '{ROW_EVAL,       REG_COEFF_COUNT, 32'h0000_0001, 32'h0000_0000, 1'b0},
    // Full degree: endpoints give the first and last coefficient.
    '{ROW_WRITE,      REG_COEFF_COUNT, 32'h0000_0007, 32'h0000_0000, 1'b0},
    '{ROW_WRITE,      REG_COEF_0,      32'h0001_0000, 32'h0000_0000, 1'b0},
    '{ROW_WRITE,      REG_COEF_1,      32'hFFFE_0000, 32'h0000_0000, 1'b0},
    '{ROW_WRITE,      REG_COEF_2,      32'h7FFF_FFFF, 32'h0000_0000, 1'b0},
    '{ROW_WRITE,      REG_COEF_3,      32'h8000_0000, 32'h0000_0000, 1'b0},
    '{ROW_WRITE,      REG_COEF_4,      32'h0003_8000, 32'h0000_0000, 1'b0},
    '{ROW_WRITE,      REG_COEF_5,      32'hFFFF_FFFF, 32'h0000_0000, 1'b0},
    '{ROW_WRITE,      REG_COEF_6,      32'h1234_5678, 32'h0000_0000, 1'b0},
    '{ROW_EVAL_TYPED, REG_COEFF_COUNT, 32'h0000_0000, 32'h0001_0000, 1'b0},
    '{ROW_EVAL_TYPED, REG_COEFF_COUNT, 32'h0001_0000, 32'h1234_5678, 1'b0},
    '{ROW_EVAL,       REG_COEFF_COUNT, 32'h0000_0001, 32'h0000_0000, 1'b0},
    '{ROW_EVAL,       REG_COEFF_COUNT, 32'h0000_FFFF, 32'h0000_0000, 1'b0},
    '{ROW_EVAL,       REG_COEFF_COUNT, 32'h0000_8000, 32'h0000_0000, 1'b0},
    '{ROW_EVAL,       REG_COEFF_COUNT, 32'h0000_5555, 32'h0000_0000, 1'b0},
    '{ROW_EVAL_TYPED, REG_COEFF_COUNT, 32'h0003_0000, 32'h0000_0000, 1'b1},
    // Smaller count: coefficients at or above it must not leak in.
    '{ROW_WRITE,      REG_COEFF_COUNT, 32'h0000_0003, 32'h0000_0000, 1'b0},
    '{ROW_EVAL,       REG_COEFF_COUNT, 32'h0000_9C40, 32'h0000_0000, 1'b0},
    '{ROW_EVAL_TYPED, REG_COEFF_COUNT, 32'h0001_0000, 32'h7FFF_FFFF, 1'b0},
    '{ROW_WRITE,      REG_COEFF_COUNT, 32'h0000_0001, 32'h0000_0000, 1'b0},
    '{ROW_EVAL_TYPED, REG_COEFF_COUNT, 32'h0000_C350, 32'h0001_0000, 1'b0}
  };

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_data;

  bdc_in_if  req_if ();
  bdc_out_if rsp_if ();

  bernstein_de_casteljau_eval i_dut (
    .clk      (clk),
    .rst      (rst),
    .req      (req_if),
    .rsp      (rsp_if),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_data (cfg_data)
  );

  always #5 clk = ~clk;

  // Shadow copy of the register file, as the block holds it after reset.
  logic [CNT_W-1:0]         coeff_count_q = CNT_W'(1);
  logic signed [COEF_W-1:0] coef_q [NUM_COEF_REGS] = '{default: '0};

  // Results in flight, oldest first.
  eval_result_t awaited_evals [$];

  int  mismatch_count = 0;
  int  cycle_count    = 0;
  bit  calm           = 1'b0;  // both sides stop idling while set
  bit  hold_request   = 1'b0;  // ask the response side for one long stall

  task automatic report_mismatch(input string what);
    $display("MISMATCH at cycle %0d: %s", cycle_count, what);
    mismatch_count++;
  endtask

  // Append a prediction behind every result still in flight.
  function automatic void queue_prediction(input eval_result_t r);
    awaited_evals.insert(awaited_evals.size(), r);
  endfunction

  function automatic void model_write(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] data);
    if (idx == REG_COEFF_COUNT) coeff_count_q = data[CNT_W-1:0];
    else coef_q[idx - REG_COEF_0] = data;
  endfunction

  // De Casteljau reduction on 64-bit signed values. Each pass blends
  // neighbors with weight t and rounds half up through a floor shift.
  function automatic eval_result_t bernstein_at(input logic signed [T_W-1:0] t);
    longint       w [MAX_COEFFS];
    longint       tt;
    int           n;
    eval_result_t r;
    tt = t;
    r.t = t;
    r.value = '0;
    r.param_error = 1'b0;
    if (tt < 0 || tt > ONE) begin
      r.param_error = 1'b1;
      return r;
    end
    n = (coeff_count_q == 0) ? 1 : int'(coeff_count_q);
    if (n > MAX_COEFFS) n = MAX_COEFFS;
    for (int k = 0; k < n; k++) w[k] = longint'(coef_q[k]);
    for (int pass = 1; pass < n; pass++)
      for (int k = 0; k < n - pass; k++)
        w[k] = ((ONE - tt) * w[k] + tt * w[k+1] + HALF) >>> FRAC_BITS;
    r.value = w[0][COEF_W-1:0];
    return r;
  endfunction

  function automatic logic [COEF_W-1:0] draw_coef();
    case ($urandom_range(0, 5))
      0:       return COEF_MAX;
      1:       return COEF_MIN;
      2:       return 32'($urandom_range(0, 32'h0020_0000)) - 32'h0010_0000;
      default: return 32'($urandom);
    endcase
  endfunction

  // Mostly legal t, with the endpoints, both sides out of range, and noise.
  function automatic logic signed [T_W-1:0] draw_t();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return T_W'(ONE);
      2:       return T_W'($urandom_range(ONE + 1, (1 << (T_W - 1)) - 1));
      3:       return T_W'(0 - $urandom_range(1, 1 << (T_W - 1)));
      4:       return T_W'($urandom);
      default: return T_W'($urandom_range(0, ONE));
    endcase
  endfunction

  // Offer one request after a random gap; return on the accepting edge
  // with valid still high so back-to-back requests need no extra step.
  task automatic send_request(input logic signed [T_W-1:0] t);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 7);
    if (gap != 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_if.valid   <= 1'b1;
    req_if.t_param <= t;
    do @(posedge clk); while (!req_if.ready);
  endtask

  // Drop valid and hold until every awaited result has been taken.
  task automatic wait_idle();
    req_if.valid <= 1'b0;
    while (awaited_evals.size() != 0) @(posedge clk);
  endtask

  // One write per edge; caller drops cfg_we after the last one.
  task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= data;
    model_write(idx, data);
    @(posedge clk);
  endtask

  task automatic load_config(input logic [CNT_W-1:0] count,
                             input logic [COEF_W-1:0] coefs [NUM_COEF_REGS]);
    wait_idle();
    write_reg(REG_COEFF_COUNT, CFG_DATA_W'(count));
    for (int k = 0; k < NUM_COEF_REGS; k++) write_reg(cfg_reg_t'(REG_COEF_0 + k), coefs[k]);
    cfg_we <= 1'b0;
  endtask

  // Response side: random stall before each result, one long hold on request.
  // The long hold lets the pipeline fill so the block has to stall requests.
  initial begin : rsp_drain
    int gap;
    forever begin
      if (hold_request) begin
        gap = HOLD_CYCLES;
        hold_request = 1'b0;
      end else begin
        gap = calm ? 0 : $urandom_range(0, 7);
      end
      if (gap != 0) begin
        rsp_if.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      rsp_if.ready <= 1'b1;
      do @(posedge clk); while (!(rsp_if.valid === 1'b1 && !rst));
    end
  end

  // Compare every accepted result, field by field, with the oldest prediction.
  always @(posedge clk) begin : check_results
    eval_result_t want;
    if (!rst && rsp_if.valid && rsp_if.ready) begin
      if (awaited_evals.size() == 0) begin
        report_mismatch($sformatf("unexpected result value %h error %b",
                                  rsp_if.value, rsp_if.param_error));
      end else begin
        want = awaited_evals.pop_front();
        if (rsp_if.value !== want.value)
          report_mismatch($sformatf("t=%0d value %h, predicted %h",
                                    want.t, rsp_if.value, want.value));
        if (rsp_if.param_error !== want.param_error)
          report_mismatch($sformatf("t=%0d param_error %b, predicted %b",
                                    want.t, rsp_if.param_error, want.param_error));
      end
    end
  end

  // Watchdog: a hung handshake ends the run here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin : stimulus
    row_t                  row;
    bit                    writing;
    eval_result_t          typed;
    logic [CNT_W-1:0]      count;
    logic [COEF_W-1:0]     coefs [NUM_COEF_REGS];
    logic signed [T_W-1:0] t;

    req_if.valid   <= 1'b0;
    req_if.t_param <= '0;
    cfg_we         <= 1'b0;
    cfg_idx        <= REG_COEFF_COUNT;
    cfg_data       <= '0;
    writing = 1'b0;

    // Hold reset once at the start, then release.
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Walk the directed table. Writes go in bursts, only once idle.
    foreach (DIRECTED_ROWS[r]) begin
      row = DIRECTED_ROWS[r];
      if (row.kind == ROW_WRITE) begin
        if (!writing) wait_idle();
        write_reg(row.idx, row.data);
        writing = 1'b1;
      end else begin
        if (writing) begin
          cfg_we <= 1'b0;
          writing = 1'b0;
        end
        t = row.data[T_W-1:0];
        send_request(t);
        if (row.kind == ROW_EVAL_TYPED) begin
          typed.t           = t;
          typed.value       = row.exp_value;
          typed.param_error = row.exp_err;
          queue_prediction(typed);
        end else begin
          queue_prediction(bernstein_at(t));
        end
      end
    end

    // Random phases, each with its own settings. The first four pin the
    // extremes: all max, all min, max/min alternating, and a count of zero.
    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      count = CNT_W'($urandom_range(0, 7));
      foreach (coefs[k]) coefs[k] = draw_coef();
      case (phase)
        0: begin
          count = CNT_W'(MAX_COEFFS);
          foreach (coefs[k]) coefs[k] = COEF_MAX;
        end
        1: begin
          count = CNT_W'(MAX_COEFFS);
          foreach (coefs[k]) coefs[k] = COEF_MIN;
        end
        2: begin
          count = CNT_W'(MAX_COEFFS);
          foreach (coefs[k]) coefs[k] = k[0] ? COEF_MIN : COEF_MAX;
        end
        3: count = '0;
        default: ;
      endcase
      load_config(count, coefs);

      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        // Alternate idle-heavy stretches with full-rate ones.
        if (n % 30 == 0) calm = ($urandom_range(0, 3) == 0);
        // Keep offering requests back to back while the output is held off.
        if (phase == 5 && n == 30) begin
          hold_request = 1'b1;
          calm = 1'b1;
        end
        // Pause the request side until the pipeline has fully drained.
        if (phase == 6 && n == 75) wait_idle();
        t = draw_t();
        send_request(t);
        queue_prediction(bernstein_at(t));
      end
    end

    calm = 1'b0;
    wait_idle();
    // Wait out DRAIN_CYCLES for any stray result to show up.
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
